// ===== design/rpu_pkg.sv =====
`default_nettype none
package rpu_pkg;

  localparam logic [2:0] FMT_1BPP  = 3'd0;
  localparam logic [2:0] FMT_4BPP  = 3'd1;
  localparam logic [2:0] FMT_8BPP  = 3'd2;
  localparam logic [2:0] FMT_16BPP = 3'd3;
  localparam logic [2:0] FMT_24BPP = 3'd4;
  localparam logic [2:0] FMT_32BPP = 3'd5;

  localparam logic OUT_RGB  = 1'b0;
  localparam logic OUT_RGBA = 1'b1;

  localparam logic [1:0] CFG_SOURCE_FORMAT = 2'd0;
  localparam logic [1:0] CFG_OUTPUT_FORMAT = 2'd1;
  localparam logic [1:0] CFG_ALPHA_VALUE   = 2'd2;

  localparam logic [2:0] SOURCE_FORMAT_RESET = FMT_8BPP;
  localparam logic       OUTPUT_FORMAT_RESET = OUT_RGB;
  localparam logic [7:0] ALPHA_VALUE_RESET   = 8'hFF;

  localparam int MAX_BYTES   = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [2:0]                last_idx;
  } rpu_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } rpu_qstat_t;

endpackage
`default_nettype wire

// ===== design/rpu_front.sv =====
`default_nettype none
module rpu_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [39:0]        s_axis_tdata,  // source_word, first_index, pixel_count, pad
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [7:0]         cfg_data,
  input  wire rpu_pkg::rpu_qstat_t qstat,
  output logic                    q_wr,
  output rpu_pkg::rpu_item_t      q_item
);

  logic [2:0] source_format;
  logic       output_format;
  logic [7:0] alpha_value;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_format <= rpu_pkg::SOURCE_FORMAT_RESET;
      output_format <= rpu_pkg::OUTPUT_FORMAT_RESET;
      alpha_value   <= rpu_pkg::ALPHA_VALUE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rpu_pkg::CFG_SOURCE_FORMAT: source_format <= cfg_data[2:0];
        rpu_pkg::CFG_OUTPUT_FORMAT: output_format <= cfg_data[0];
        rpu_pkg::CFG_ALPHA_VALUE:   alpha_value   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [31:0] word;
  logic [2:0]  first;
  logic [3:0]  count;
  logic [3:0]  left1, left4, k1, k4, n;
  logic [rpu_pkg::MAX_BYTES-1:0][7:0] mono, nib, bytes;

  assign word  = s_axis_tdata[31:0];
  assign first = s_axis_tdata[34:32];
  assign count = s_axis_tdata[38:35];

  always_comb begin
    logic [2:0] pos;
    pos = 3'd0;
    for (int i = 0; i < rpu_pkg::MAX_BYTES; i++) begin
      pos     = first + 3'(i);
      mono[i] = word[pos] ? 8'hFF : 8'h00;
      nib[i]  = {(pos[0] ? word[7:4] : word[3:0]), 4'h0};
    end
  end

  always_comb begin
    left1 = 4'd8 - {1'b0, first};
    k1    = (count < left1) ? count : left1;
    left4 = 4'd2 - {1'b0, first};
    if (first >= 3'd2) k4 = 4'd0;
    else               k4 = (count < left4) ? count : left4;
  end

  always_comb begin
    bytes = '0;
    n     = 4'd0;
    case (source_format)
      rpu_pkg::FMT_1BPP: begin
        bytes = mono;
        n     = k1;
      end
      rpu_pkg::FMT_4BPP: begin
        bytes = nib;
        n     = k4;
      end
      rpu_pkg::FMT_8BPP: begin
        bytes[0] = word[7:0];
        n        = 4'd1;
      end
      rpu_pkg::FMT_16BPP: begin
        bytes[0] = {word[14:10], 3'b000};
        bytes[1] = {word[9:5], 3'b000};
        bytes[2] = {word[4:0], 3'b000};
        bytes[3] = alpha_value;
        n        = (output_format == rpu_pkg::OUT_RGBA) ? 4'd4 : 4'd3;
      end
      rpu_pkg::FMT_24BPP, rpu_pkg::FMT_32BPP: begin
        bytes[0] = word[23:16];
        bytes[1] = word[15:8];
        bytes[2] = word[7:0];
        bytes[3] = alpha_value;
        n        = (output_format == rpu_pkg::OUT_RGBA) ? 4'd4 : 4'd3;
      end
      default: begin
        bytes = '0;
        n     = 4'd0;
      end
    endcase
  end

  logic [3:0] n_m1;
  assign n_m1 = n - 4'd1;

  assign s_axis_tready   = !qstat.full;
  assign q_wr            = s_axis_tvalid && s_axis_tready && (n != 4'd0);
  assign q_item.bytes    = bytes;
  assign q_item.last_idx = n_m1[2:0];

endmodule
`default_nettype wire

// ===== design/rpu_queue.sv =====
`default_nettype none
module rpu_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                wr,
  input  wire rpu_pkg::rpu_item_t  wr_item,
  input  wire logic                rd,
  output rpu_pkg::rpu_item_t       rd_item,
  output rpu_pkg::rpu_qstat_t      qstat
);

  rpu_pkg::rpu_item_t mem [rpu_pkg::QUEUE_DEPTH];
  logic [rpu_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [rpu_pkg::QPTR_W:0]   cnt;

  always_ff @(posedge clk) begin
    if (wr) mem[wr_ptr] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + 1'b1;
      if (rd) rd_ptr <= rd_ptr + 1'b1;
      case ({wr, rd})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  assign rd_item     = mem[rd_ptr];
  assign qstat.full  = (cnt == (rpu_pkg::QPTR_W+1)'(rpu_pkg::QUEUE_DEPTH));
  assign qstat.empty = (cnt == '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) wr |-> !qstat.full)
    else $error("queue write while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) rd |-> !qstat.empty)
    else $error("queue read while empty");
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= (rpu_pkg::QPTR_W+1)'(rpu_pkg::QUEUE_DEPTH))
    else $error("queue count out of range");
  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    (wr && !rd) |=> (cnt == $past(cnt) + 1'b1))
    else $error("queue count did not follow write");

endmodule
`default_nettype wire

// ===== design/rpu_back.sv =====
`default_nettype none
module rpu_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire rpu_pkg::rpu_qstat_t qstat,
  input  wire rpu_pkg::rpu_item_t  q_item,
  output logic                     q_rd,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [7:0]               m_axis_tdata,  // out_byte
  output logic                     m_axis_tlast   // last_of_item
);

  rpu_pkg::rpu_item_t cur;
  logic               cur_valid;
  logic [2:0]         idx;
  logic               adv, emit, cur_last, cur_done;

  assign adv      = !m_axis_tvalid || m_axis_tready;
  assign emit     = adv && cur_valid;
  assign cur_last = (idx == cur.last_idx);
  assign cur_done = emit && cur_last;
  assign q_rd     = !qstat.empty && (!cur_valid || cur_done);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid     <= 1'b0;
      idx           <= 3'd0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (adv) m_axis_tvalid <= cur_valid;
      if (q_rd) begin
        cur_valid <= 1'b1;
        idx       <= 3'd0;
      end else begin
        if (emit) idx <= idx + 3'd1;
        if (cur_done) cur_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) cur <= q_item;
    if (emit) begin
      m_axis_tdata <= cur.bytes[idx];
      m_axis_tlast <= cur_last;
    end
  end

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (idx <= cur.last_idx))
    else $error("byte index past end of item");
  a_load_resets_idx: assert property (@(posedge clk) disable iff (rst)
    q_rd |=> (idx == 3'd0 && cur_valid))
    else $error("item load did not restart index");
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    emit |=> m_axis_tvalid)
    else $error("emitted byte not presented");

endmodule
`default_nettype wire

// ===== design/raster_pixel_unpacker.sv =====
// Path: input beat -> item queue -> current-item register -> registered output byte.
// Throughput: one output byte per cycle while the sink is ready; an item gives one
// byte (8 bpp), three or four (16/24/32 bpp) or up to eight (1 bpp).
// A four-entry item queue lets input beats keep arriving while bytes drain.
// Reset: synchronous, clears queue and output valid, restores config defaults.
`default_nettype none
module raster_pixel_unpacker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // source_word, first_index, pixel_count, pad
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // out_byte
  output logic             m_axis_tlast,  // last_of_item
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  rpu_pkg::rpu_qstat_t qstat;
  rpu_pkg::rpu_item_t  wr_item, rd_item;
  logic                q_wr, q_rd;

  rpu_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .qstat         (qstat),
    .q_wr          (q_wr),
    .q_item        (wr_item)
  );

  rpu_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_item (wr_item),
    .rd      (q_rd),
    .rd_item (rd_item),
    .qstat   (qstat)
  );

  rpu_back u_back (
    .clk           (clk),
    .rst           (rst),
    .qstat         (qstat),
    .q_item        (rd_item),
    .q_rd          (q_rd),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
`default_nettype wire

// ===== sim/raster_pixel_unpacker_tb.sv =====
module raster_pixel_unpacker_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  first;
    logic [3:0]  count;
  } src_beat_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } comp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // source_word, first_index, pixel_count, pad
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [7:0]  m_axis_tdata;        // out_byte
  logic        m_axis_tlast;        // last_of_item
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  // shadow copy of the registers
  logic [2:0] src_fmt = rpu_pkg::SOURCE_FORMAT_RESET;
  logic       out_fmt = rpu_pkg::OUTPUT_FORMAT_RESET;
  logic [7:0] alpha   = rpu_pkg::ALPHA_VALUE_RESET;

  src_beat_t src_beats[$];
  comp_t     unpacked_q[$];
  bit        idle_on = 1'b0;
  int        src_gap = 0;
  int        sink_stall = 0;
  int        errors = 0;
  int        cycles = 0;

  raster_pixel_unpacker dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int draw_wait();
    return idle_on ? $urandom_range(0, 7) : 0;
  endfunction

  // expand one source word into component bytes under the current register values
  function automatic void unpack_word(logic [31:0] w, logic [2:0] first, logic [3:0] count);
    logic [7:0] b[$];
    int left;
    int npx;
    int i;
    comp_t c;
    case (src_fmt)
      rpu_pkg::FMT_1BPP: begin
        left = 8 - int'(first);
        npx = (int'(count) < left) ? int'(count) : left;
        for (i = 0; i < npx; i++) b.push_back(w[int'(first) + i] ? 8'hFF : 8'h00);
      end
      rpu_pkg::FMT_4BPP: begin
        left = (first >= 2) ? 0 : 2 - int'(first);
        npx = (int'(count) < left) ? int'(count) : left;
        for (i = 0; i < npx; i++) b.push_back({w[4 * (int'(first) + i) +: 4], 4'h0});
      end
      rpu_pkg::FMT_8BPP: b.push_back(w[7:0]);
      rpu_pkg::FMT_16BPP: begin
        b.push_back({w[14:10], 3'b000});
        b.push_back({w[9:5], 3'b000});
        b.push_back({w[4:0], 3'b000});
        if (out_fmt == rpu_pkg::OUT_RGBA) b.push_back(alpha);
      end
      rpu_pkg::FMT_24BPP, rpu_pkg::FMT_32BPP: begin
        b.push_back(w[23:16]);
        b.push_back(w[15:8]);
        b.push_back(w[7:0]);
        if (out_fmt == rpu_pkg::OUT_RGBA) b.push_back(alpha);
      end
      default: ;
    endcase
    for (i = 0; i < b.size(); i++) begin
      c.data = b[i];
      c.last = (i == b.size() - 1);
      unpacked_q.push_back(c);
    end
  endfunction

  // source side
  always @(posedge clk) begin
    logic      nv;
    int        g;
    src_beat_t nb;
    nv = s_axis_tvalid;
    g = src_gap;
    if (rst) begin
      nv = 1'b0;
      g = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        unpack_word(s_axis_tdata[31:0], s_axis_tdata[34:32], s_axis_tdata[38:35]);
        g = draw_wait();
        nv = 1'b0;
      end
      if (!nv) begin
        if (g > 0) begin
          g--;
        end else if (src_beats.size() > 0) begin
          nb = src_beats.pop_front();
          s_axis_tdata <= {1'b0, nb.count, nb.first, nb.word};
          nv = 1'b1;
        end
      end
    end
    s_axis_tvalid <= nv;
    src_gap <= g;
  end

  // sink side
  always @(posedge clk) begin
    logic  r;
    int    st;
    comp_t want;
    r = m_axis_tready;
    st = sink_stall;
    if (rst) begin
      r = 1'b1;
      st = 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      if (unpacked_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat: expected none, actual data %h last %b",
                 $time, m_axis_tdata, m_axis_tlast);
      end else begin
        want = unpacked_q.pop_front();
        if (m_axis_tdata !== want.data) begin
          errors++;
          $display("%0t: out_byte mismatch: expected %h, actual %h",
                   $time, want.data, m_axis_tdata);
        end
        if (m_axis_tlast !== want.last) begin
          errors++;
          $display("%0t: last_of_item mismatch: expected %b, actual %b",
                   $time, want.last, m_axis_tlast);
        end
      end
      st = draw_wait();
      if (st > 0) r = 1'b0;
    end else if (!r) begin
      if (st > 0) st--;
      if (st == 0) r = 1'b1;
    end
    m_axis_tready <= r;
    sink_stall <= st;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** raster_pixel_unpacker: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      rpu_pkg::CFG_SOURCE_FORMAT: src_fmt = val[2:0];
      rpu_pkg::CFG_OUTPUT_FORMAT: out_fmt = val[0];
      rpu_pkg::CFG_ALPHA_VALUE:   alpha = val;
      default: ;
    endcase
  endtask

  // unused upper bits of the narrow registers carry random junk
  task automatic set_config(input int fmt, input int ofmt, input int a);
    logic [7:0] v;
    idle_on = ($urandom_range(0, 3) != 0);
    v = 8'($urandom);
    v[2:0] = fmt[2:0];
    write_reg(rpu_pkg::CFG_SOURCE_FORMAT, v);
    v = 8'($urandom);
    v[0] = ofmt[0];
    write_reg(rpu_pkg::CFG_OUTPUT_FORMAT, v);
    write_reg(rpu_pkg::CFG_ALPHA_VALUE, a[7:0]);
    @(negedge clk);
  endtask

  task automatic push_item(input logic [31:0] w, input int first, input int count);
    src_beat_t b;
    b.word = w;
    b.first = first[2:0];
    b.count = count[3:0];
    src_beats.push_back(b);
  endtask

  task automatic drain();
    do @(negedge clk); while (src_beats.size() != 0 || s_axis_tvalid || unpacked_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int fmt;
    int ofmt;
    int a;
    int first;
    int count;
    int p;
    int k;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset values: 8 bpp copy
    push_item(32'h0000_0000, 0, 1);
    push_item(32'hFFFF_FFFF, 7, 15);
    drain();

    set_config(rpu_pkg::FMT_1BPP, rpu_pkg::OUT_RGBA, 8'h00);
    push_item(32'h0000_00A5, 0, 8);
    push_item(32'hFFFF_FFFF, 7, 15);
    push_item(32'h0000_005A, 3, 0);
    push_item(32'h0000_0001, 0, 1);
    drain();

    set_config(rpu_pkg::FMT_4BPP, rpu_pkg::OUT_RGB, 8'hFF);
    push_item(32'h0000_00C3, 0, 2);
    push_item(32'hFFFF_FFFF, 1, 15);
    push_item(32'h0000_0012, 2, 4);
    push_item(32'h0000_007E, 0, 1);
    drain();

    set_config(rpu_pkg::FMT_16BPP, rpu_pkg::OUT_RGB, 8'h5A);
    push_item(32'hFFFF_FFFF, 0, 0);
    push_item(32'h0000_0000, 7, 15);
    push_item(32'h0000_2D6B, 0, 1);
    drain();

    set_config(rpu_pkg::FMT_24BPP, rpu_pkg::OUT_RGBA, 8'h00);
    push_item(32'h0012_3456, 0, 0);
    push_item(32'hFFFF_FFFF, 7, 15);
    drain();

    set_config(rpu_pkg::FMT_32BPP, rpu_pkg::OUT_RGBA, 8'hFF);
    push_item(32'hA1B2_C3D4, 3, 5);
    push_item(32'h0000_0000, 0, 1);
    drain();

    // reserved source formats produce nothing
    set_config(6, rpu_pkg::OUT_RGBA, 8'h80);
    push_item(32'hDEAD_BEEF, 0, 8);
    drain();
    set_config(7, rpu_pkg::OUT_RGB, 8'h80);
    push_item(32'h1234_5678, 1, 1);
    drain();

    for (p = 0; p < 10; p++) begin
      fmt = $urandom_range(0, 15);
      if (fmt > 7) fmt = $urandom_range(0, 5);
      ofmt = $urandom_range(0, 1);
      a = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 255 : 0) : $urandom_range(0, 255);
      set_config(fmt, ofmt, a);
      for (k = 0; k < 9; k++) begin
        if ($urandom_range(0, 4) != 0) begin
          if (fmt == rpu_pkg::FMT_4BPP) begin
            first = $urandom_range(0, 1);
            count = $urandom_range(1, 2 - first);
          end else begin
            first = $urandom_range(0, 7);
            count = $urandom_range(1, 8 - first);
          end
        end else begin
          first = $urandom_range(0, 7);
          count = $urandom_range(0, 15);
        end
        push_item($urandom, first, count);
      end
      drain();
    end

    if (errors == 0) begin
      $display("** raster_pixel_unpacker: PASSED **");
    end else begin
      $display("** raster_pixel_unpacker: FAILED **");
    end
    $finish;
  end

endmodule
